// File: src/swd_pkg.sv
`default_nettype none

package swd_pkg;

	localparam int unsigned CfgIdxW = 3;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_STARVE_TIMEOUT  = 3'd0,
		CFG_REBOOT_ENABLE   = 3'd1,
		CFG_REBOOT_AFTER    = 3'd2,
		CFG_REQUIRE_JUMP    = 3'd3,
		CFG_CLOCK_JUMP      = 3'd4,
		CFG_MICRO_STEP      = 3'd5
	} cfg_idx_t;

	typedef enum logic {
		OP_HEARTBEAT = 1'b0,
		OP_CHECK     = 1'b1
	} op_t;

	localparam logic [31:0] StarveTimeoutRst = 32'd60000;
	localparam logic        RebootEnableRst  = 1'b1;
	localparam logic [31:0] RebootAfterRst   = 32'd0;
	localparam logic        RequireJumpRst   = 1'b1;
	localparam logic [31:0] ClockJumpRst     = 32'd5000;
	localparam logic [30:0] MicroStepRst     = 31'd100;

	typedef struct packed {
		logic [31:0] starve_timeout_ms;
		logic        reboot_enable;
		logic [31:0] reboot_after_ms;
		logic        require_clock_jump;
		logic [31:0] clock_jump_ms;
		logic [30:0] micro_step_ms;
	} cfg_t;

	typedef struct packed {
		logic        op;
		logic [31:0] tick_ms;
		logic [31:0] timer_ms;
	} item_t;

	typedef struct packed {
		logic               reboot_request;
		logic               jump_alarm;
		logic               stall_active;
		logic               micro_stall;
		logic signed [31:0] divergence_ms;
		logic [15:0]        stall_total;
		logic [15:0]        reboot_total;
		logic [15:0]        micro_total;
		logic [31:0]        time_lost_ms;
		logic [31:0]        last_duration_ms;
		logic signed [31:0] last_jump_ms;
	} result_t;

	typedef struct packed {
		logic        armed;
		logic        halted;
		logic [31:0] last_beat;
		logic        in_stall;
		logic [31:0] stall_start;
		logic [31:0] peak_jump;
		logic [31:0] pending_duration;
		logic        recovery_pending;
		logic [31:0] healthy_div;
		logic        healthy_valid;
		logic [31:0] prev_div;
		logic        prev_valid;
		logic        skip_next_step;
		logic [15:0] stall_count;
		logic [15:0] reboot_count;
		logic [15:0] micro_count;
		logic [31:0] lost_total;
		logic [31:0] rec_duration;
		logic [31:0] rec_jump;
	} state_t;

	typedef struct packed {
		logic load;
		logic fire;
	} flow_t;

	function automatic logic [15:0] inc_sat16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic [31:0] add_sat32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

endpackage

`default_nettype wire

// File: src/swd_cfg.sv
`default_nettype none

module swd_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [swd_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [31:0]                 cfg_data,
	output swd_pkg::cfg_t                    cfg
);
	import swd_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.starve_timeout_ms  <= StarveTimeoutRst;
			cfg_q.reboot_enable      <= RebootEnableRst;
			cfg_q.reboot_after_ms    <= RebootAfterRst;
			cfg_q.require_clock_jump <= RequireJumpRst;
			cfg_q.clock_jump_ms      <= ClockJumpRst;
			cfg_q.micro_step_ms      <= MicroStepRst;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_STARVE_TIMEOUT: cfg_q.starve_timeout_ms  <= cfg_data;
				CFG_REBOOT_ENABLE:  cfg_q.reboot_enable      <= cfg_data[0];
				CFG_REBOOT_AFTER:   cfg_q.reboot_after_ms    <= cfg_data;
				CFG_REQUIRE_JUMP:   cfg_q.require_clock_jump <= cfg_data[0];
				CFG_CLOCK_JUMP:     cfg_q.clock_jump_ms      <= cfg_data;
				CFG_MICRO_STEP:     cfg_q.micro_step_ms      <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: src/swd_flow.sv
`default_nettype none

module swd_flow (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     item_valid,
	output logic          item_stall,
	output logic          result_valid,
	input  wire logic     result_stall,
	output swd_pkg::flow_t flow
);
	import swd_pkg::*;

	logic valid_s1;
	logic valid_s2;
	logic advance;

	assign advance      = !valid_s2 || !result_stall;
	assign item_stall   = valid_s1 && !advance;
	assign result_valid = valid_s2;
	assign flow.load    = item_valid && !item_stall;
	assign flow.fire    = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= flow.load || (valid_s1 && !flow.fire);
			valid_s2 <= flow.fire || (valid_s2 && result_stall);
		end
	end

endmodule

`default_nettype wire

// File: src/swd_core.sv
`default_nettype none

module swd_core (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  swd_pkg::cfg_t  cfg,
	input  swd_pkg::item_t item,
	input  wire logic      fire,
	output swd_pkg::result_t res
);
	import swd_pkg::*;

	state_t      st_q;
	state_t      st_d;
	logic [31:0] div;
	logic [31:0] step;
	logic [31:0] starved;
	logic [31:0] start;
	logic [31:0] peak;
	logic [31:0] stall_len;
	logic [31:0] jump;
	logic [31:0] jump_mag;
	logic [31:0] lost_amt;
	logic        lost_en;
	logic        clk_flag;
	logic        micro;
	logic        reboot;
	logic [31:0] reboot_jump;

	assign div       = item.tick_ms - item.timer_ms;
	assign step      = div - st_q.prev_div;
	assign starved   = item.tick_ms - st_q.last_beat;
	assign start     = st_q.in_stall ? st_q.stall_start : st_q.last_beat;
	assign peak      = st_q.in_stall ? st_q.peak_jump : 32'd0;
	assign stall_len = item.tick_ms - start;
	assign jump      = st_q.healthy_valid ? (div - st_q.healthy_div) : 32'd0;
	assign jump_mag  = mag32(jump);

	always_comb begin
		st_d        = st_q;
		lost_amt    = 32'd0;
		lost_en     = 1'b0;
		clk_flag    = 1'b0;
		micro       = 1'b0;
		reboot      = 1'b0;
		reboot_jump = 32'd0;
		if (!st_q.halted && op_t'(item.op) == OP_HEARTBEAT) begin
			st_d.last_beat = item.tick_ms;
			st_d.armed     = 1'b1;
			if (st_q.recovery_pending) begin
				st_d.recovery_pending = 1'b0;
				st_d.skip_next_step   = 1'b1;
				st_d.rec_duration     = st_q.pending_duration;
				st_d.rec_jump         = st_q.peak_jump;
				st_d.stall_count      = inc_sat16(st_q.stall_count);
				lost_amt              = st_q.pending_duration;
				lost_en               = 1'b1;
			end
			st_d.healthy_div   = div;
			st_d.healthy_valid = 1'b1;
			st_d.prev_div      = div;
			st_d.prev_valid    = 1'b1;
			if (st_q.prev_valid) begin
				if (st_d.skip_next_step) begin
					st_d.skip_next_step = 1'b0;
				end else if (!step[31] && step > {1'b0, cfg.micro_step_ms}) begin
					micro            = 1'b1;
					st_d.micro_count = inc_sat16(st_q.micro_count);
					lost_amt         = step;
					lost_en          = 1'b1;
				end
			end
		end else if (!st_q.halted && st_q.armed) begin
			if (starved <= cfg.starve_timeout_ms) begin
				if (st_q.in_stall) begin
					st_d.in_stall         = 1'b0;
					st_d.pending_duration = item.tick_ms - st_q.stall_start;
					st_d.recovery_pending = 1'b1;
				end
			end else begin
				st_d.in_stall    = 1'b1;
				st_d.stall_start = start;
				st_d.peak_jump   = peak;
				if (cfg.reboot_enable && cfg.reboot_after_ms != 32'd0
				    && stall_len >= cfg.reboot_after_ms) begin
					reboot = 1'b1;
				end else begin
					if (jump_mag > mag32(peak))
						st_d.peak_jump = jump;
					clk_flag    = jump_mag >= cfg.clock_jump_ms;
					reboot_jump = jump;
					reboot      = cfg.reboot_enable && (!cfg.require_clock_jump || clk_flag);
				end
			end
			if (reboot) begin
				st_d.rec_duration = stall_len;
				st_d.rec_jump     = reboot_jump;
				st_d.stall_count  = inc_sat16(st_q.stall_count);
				st_d.reboot_count = inc_sat16(st_q.reboot_count);
				st_d.halted       = 1'b1;
				lost_amt          = stall_len;
				lost_en           = 1'b1;
			end
		end
		if (lost_en)
			st_d.lost_total = add_sat32(st_q.lost_total, lost_amt);
	end

	always_comb begin
		res.reboot_request   = st_d.halted;
		res.jump_alarm       = clk_flag;
		res.stall_active     = st_d.in_stall;
		res.micro_stall      = micro;
		res.divergence_ms    = div;
		res.stall_total      = st_d.stall_count;
		res.reboot_total     = st_d.reboot_count;
		res.micro_total      = st_d.micro_count;
		res.time_lost_ms     = st_d.lost_total;
		res.last_duration_ms = st_d.rec_duration;
		res.last_jump_ms     = st_d.rec_jump;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire) begin
			st_q <= st_d;
		end
	end

endmodule

`default_nettype wire

// File: src/stall_watchdog_with_clock_check_top.sv
// Channel   Handshake                  Payload
// item      item_valid / item_stall    item (op, tick_ms, timer_ms)
// result    result_valid / result_stall result (flags, counters, stall record)
// cfg       cfg_valid / cfg_ready      cfg_index, cfg_data
//
// result_valid rises once the result register loads; item path: input register, then
// the stall tracking logic and state update feed the result register.
// One item per cycle sustained while result_stall is low; the state register updates on each fire.
// cfg_ready is always high. arst_n clears flags and counters, restores config defaults.
// A held result stalls the input register; item_stall then rises.
`default_nettype none

module stall_watchdog_with_clock_check_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        item_valid,
	output logic                             item_stall,
	input  swd_pkg::item_t                   item,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output swd_pkg::result_t                 result,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [swd_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [31:0]                 cfg_data
);
	import swd_pkg::*;

	cfg_t    cfg;
	flow_t   flow;
	item_t   item_s1;
	result_t res;
	result_t result_s2;

	swd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	swd_flow u_flow (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.flow         (flow)
	);

	swd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.fire   (flow.fire),
		.res    (res)
	);

	always_ff @(posedge clk) begin
		if (flow.load)
			item_s1 <= item;
		if (flow.fire)
			result_s2 <= res;
	end

	assign result = result_s2;

endmodule

`default_nettype wire

// File: src/swd_checker.sv
`default_nettype none

module swd_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             result_valid,
	input wire logic             result_stall,
	input swd_pkg::result_t      result
);
	import swd_pkg::*;

	logic        out_xact;
	logic        seen_reboot_q;
	logic [15:0] stall_total_q;
	logic [15:0] reboot_total_q;

	assign out_xact = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_reboot_q  <= 1'b0;
			stall_total_q  <= 16'd0;
			reboot_total_q <= 16'd0;
		end else if (out_xact) begin
			seen_reboot_q  <= seen_reboot_q || result.reboot_request;
			stall_total_q  <= result.stall_total;
			reboot_total_q <= result.reboot_total;
		end
	end

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	a_reboot_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_xact && seen_reboot_q |-> result.reboot_request)
		else $error("reboot request cleared without reset");

	a_counts_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		out_xact |-> result.stall_total >= stall_total_q
		          && result.reboot_total >= reboot_total_q)
		else $error("counter went backwards");

	a_reboot_le_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_xact |-> result.reboot_total <= result.stall_total)
		else $error("more reboots than stalls");

	a_micro_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_xact && result.micro_stall |-> !result.reboot_request && !result.jump_alarm)
		else $error("micro-stall flagged on a check or while halted");

endmodule

bind stall_watchdog_with_clock_check_top swd_checker u_swd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

`default_nettype wire
